@@ rtl/core/fec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Focus error S-curve detector package
// Shared widths, phase and command codes, register indexes.
// ----------------------------------------------------------------------------
package fec_pkg;

	// field widths
	localparam int SAMPLE_BITS  = 10;
	localparam int TIMEOUT_BITS = 16;
	localparam int POS_BITS     = 8;
	localparam int DIV_BITS     = 8;
	localparam int PHASE_BITS   = 3;
	localparam int CMD_BITS     = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	// serial multiplier: deviation times divisor
	localparam int PROD_BITS = SAMPLE_BITS + DIV_BITS;
	localparam int STEP_BITS = $clog2(DIV_BITS);

	// stream payload widths, rounded up to whole bytes
	localparam int IN_USED_BITS  = CMD_BITS + SAMPLE_BITS + POS_BITS;
	localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
	localparam int OUT_USED_BITS = PHASE_BITS + SAMPLE_BITS + POS_BITS;
	localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

	// phase codes
	localparam logic [PHASE_BITS-1:0] PH_WAIT    = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_AMPL    = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_FOCUS   = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_SCURVE  = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_FOCUSED = 3'd4;
	localparam logic [PHASE_BITS-1:0] PH_ERROR   = 3'd5;

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_WAIT  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_AMPL  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_FOCUS = 2'd2;

	// request kinds (tuser)
	localparam logic ACT_CMD    = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_REFERENCE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NOISE_DIV = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAPT_DIV  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT   = 2'd3;

	// reset values of the registers
	localparam logic [SAMPLE_BITS-1:0]  RST_REFERENCE = 10'd512;
	localparam logic [DIV_BITS-1:0]     RST_NOISE_DIV = 8'd4;
	localparam logic [DIV_BITS-1:0]     RST_CAPT_DIV  = 8'd8;
	localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT   = 16'd1000;

endpackage

@@ rtl/core/fec_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add, one multiplier bit per cycle, MSB first. The product is
// valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module fec_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [fec_pkg::SAMPLE_BITS-1:0]   mcand,
	input  logic [fec_pkg::DIV_BITS-1:0]      mplier,
	output logic                              done,
	output logic [fec_pkg::PROD_BITS-1:0]     product
);

	logic                             run_q;
	logic                             done_q;
	logic [fec_pkg::STEP_BITS-1:0]    cnt_q;
	logic [fec_pkg::SAMPLE_BITS-1:0]  mcand_q;
	logic [fec_pkg::DIV_BITS-1:0]     mplier_q;
	logic [fec_pkg::PROD_BITS-1:0]    acc_q;
	logic [fec_pkg::PROD_BITS-1:0]    addend;
	logic                             last_step;

	// partial product for the current multiplier bit
	assign addend = mplier_q[fec_pkg::DIV_BITS-1] ?
		fec_pkg::PROD_BITS'(mcand_q) : '0;

	assign last_step = (cnt_q == fec_pkg::STEP_BITS'(fec_pkg::DIV_BITS - 1));

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && last_step;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step)
					run_q <= 1'b0;
			end
		end
	end

	// operand shift and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (run_q) begin
			mplier_q <= {mplier_q[fec_pkg::DIV_BITS-2:0], 1'b0};
			acc_q    <= {acc_q[fec_pkg::PROD_BITS-2:0], 1'b0} + addend;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ rtl/core/focus_error_scurve_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Focus error S-curve detector core
// Phase sequencer for amplitude measurement, S-curve departure and focus
// capture, with a bit-serial threshold multiplier.
// ----------------------------------------------------------------------------
// One request is worked on at a time and each gives one result. Commands and
// samples outside the focus and S-curve phases go from accept through ST_OUT to
// the result register; samples in the focus or S-curve phase first wait in ST_MUL
// for the 8-step bit-serial multiplier that forms deviation times divisor
// (compared against the amplitude instead of dividing it). A new request is
// taken as soon as the previous result has moved into the output register,
// so a stalled output holds at most one waiting result plus one in work.
// Configuration writes are always taken and should be made while idle.
// ----------------------------------------------------------------------------
module focus_error_scurve_detector_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fec_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [fec_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	// request stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [1:0] command_phase, [11:2] sample, [19:12] servo_position, rest zero
	input  logic [fec_pkg::IN_DATA_BITS-1:0]      s_tdata,
	// [0] action
	input  logic [0:0]                            s_tuser,
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [2:0] phase, [12:3] amplitude, [20:13] focus_position, rest zero
	output logic [fec_pkg::OUT_DATA_BITS-1:0]     m_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t                                state_q;

	// configuration registers
	logic [fec_pkg::SAMPLE_BITS-1:0]       ref_q;
	logic [fec_pkg::DIV_BITS-1:0]          ndiv_q;
	logic [fec_pkg::DIV_BITS-1:0]          cdiv_q;
	logic [fec_pkg::TIMEOUT_BITS-1:0]      limit_q;

	// detector state
	logic [fec_pkg::PHASE_BITS-1:0]        phase_q;
	logic [fec_pkg::SAMPLE_BITS-1:0]       max_q;
	logic [fec_pkg::SAMPLE_BITS-1:0]       min_q;
	logic [fec_pkg::SAMPLE_BITS-1:0]       amp_q;
	logic [fec_pkg::TIMEOUT_BITS-1:0]      timeout_q;
	logic [fec_pkg::POS_BITS-1:0]          fpos_q;
	logic [fec_pkg::POS_BITS-1:0]          pos_q;

	// output register
	logic                                  m_tvalid_q;
	logic [fec_pkg::OUT_DATA_BITS-1:0]     m_tdata_q;

	// request fields
	logic                                  in_action;
	logic [fec_pkg::CMD_BITS-1:0]          in_cmd;
	logic [fec_pkg::SAMPLE_BITS-1:0]       in_sample;
	logic [fec_pkg::POS_BITS-1:0]          in_pos;

	logic                                  accept;
	logic                                  search;
	logic [fec_pkg::SAMPLE_BITS-1:0]       dev;
	logic [fec_pkg::DIV_BITS-1:0]          div_sel;
	logic [fec_pkg::DIV_BITS-1:0]          div_eff;
	logic                                  mul_start;
	logic                                  mul_done;
	logic [fec_pkg::PROD_BITS-1:0]         mul_prod;
	logic [fec_pkg::PROD_BITS-1:0]         amp_ext;
	logic                                  hit;
	logic                                  to_fail;
	logic                                  to_inc;
	logic                                  out_free;

	assign in_action = s_tuser[0];
	assign in_cmd    = s_tdata[fec_pkg::CMD_BITS-1:0];
	assign in_sample = s_tdata[fec_pkg::CMD_BITS +: fec_pkg::SAMPLE_BITS];
	assign in_pos    = s_tdata[fec_pkg::CMD_BITS + fec_pkg::SAMPLE_BITS +: fec_pkg::POS_BITS];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign search    = (phase_q == fec_pkg::PH_FOCUS) || (phase_q == fec_pkg::PH_SCURVE);

	// deviation from reference and divisor for this phase (zero acts as one)
	assign dev       = (in_sample > ref_q) ? (in_sample - ref_q) : (ref_q - in_sample);
	assign div_sel   = (phase_q == fec_pkg::PH_FOCUS) ? ndiv_q : cdiv_q;
	assign div_eff   = (div_sel == '0) ? fec_pkg::DIV_BITS'(1) : div_sel;
	assign mul_start = accept && (in_action == fec_pkg::ACT_SAMPLE) && search;

	// dev > amp/div  <=>  dev*div > amp
	assign amp_ext = fec_pkg::PROD_BITS'(amp_q);
	assign hit     = (phase_q == fec_pkg::PH_FOCUS) ? (mul_prod > amp_ext) :
		(mul_prod <= amp_ext);
	assign to_fail = timeout_q > limit_q;
	assign to_inc  = timeout_q != '1;

	assign out_free = !m_tvalid_q || m_tready;

	fec_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (dev),
		.mplier  (div_eff),
		.done    (mul_done),
		.product (mul_prod)
	);

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= fec_pkg::RST_REFERENCE;
			ndiv_q  <= fec_pkg::RST_NOISE_DIV;
			cdiv_q  <= fec_pkg::RST_CAPT_DIV;
			limit_q <= fec_pkg::RST_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fec_pkg::REG_REFERENCE: ref_q   <= cfg_data[fec_pkg::SAMPLE_BITS-1:0];
				fec_pkg::REG_NOISE_DIV: ndiv_q  <= cfg_data[fec_pkg::DIV_BITS-1:0];
				fec_pkg::REG_CAPT_DIV:  cdiv_q  <= cfg_data[fec_pkg::DIV_BITS-1:0];
				fec_pkg::REG_TIMEOUT:   limit_q <= cfg_data[fec_pkg::TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, detector state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= fec_pkg::PH_WAIT;
			max_q      <= '0;
			min_q      <= '1;
			amp_q      <= '0;
			timeout_q  <= '0;
			fpos_q     <= '0;
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// result taken; a reload in ST_OUT keeps valid up instead
			if (m_tvalid_q && m_tready && (state_q != ST_OUT))
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= mul_start ? ST_MUL : ST_OUT;
						if (in_action == fec_pkg::ACT_CMD) begin
							unique case (in_cmd)
								fec_pkg::CMD_WAIT: begin
									phase_q   <= fec_pkg::PH_WAIT;
									timeout_q <= '0;
								end
								fec_pkg::CMD_AMPL: begin
									phase_q <= fec_pkg::PH_AMPL;
									max_q   <= '0;
									min_q   <= '1;
									amp_q   <= '0;
								end
								fec_pkg::CMD_FOCUS: begin
									amp_q   <= (min_q > max_q) ? '0 : (max_q - min_q);
									phase_q <= fec_pkg::PH_FOCUS;
								end
								default: ;
							endcase
						end else begin
							unique case (phase_q)
								fec_pkg::PH_WAIT: timeout_q <= '0;
								fec_pkg::PH_AMPL: begin
									if (in_sample > max_q) max_q <= in_sample;
									if (in_sample < min_q) min_q <= in_sample;
								end
								fec_pkg::PH_FOCUS, fec_pkg::PH_SCURVE: begin
									pos_q <= in_pos;
								end
								default: ;
							endcase
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_OUT;
						if (hit && (phase_q == fec_pkg::PH_FOCUS)) begin
							timeout_q <= '0;
							phase_q   <= fec_pkg::PH_SCURVE;
						end else if (hit) begin
							fpos_q  <= pos_q;
							phase_q <= fec_pkg::PH_FOCUSED;
						end else begin
							if (to_fail) phase_q <= fec_pkg::PH_ERROR;
							if (to_inc) timeout_q <= timeout_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(fec_pkg::OUT_DATA_BITS - fec_pkg::OUT_USED_BITS){1'b0}},
							fpos_q, amp_q, phase_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// multiplier only reports back while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL))
		else $error("multiplier done outside multiply state");

	// a search-phase sample always goes through the multiplier
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> (state_q == ST_MUL))
		else $error("search sample did not start multiply");

	// entering S-curve clears the timeout counter
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == fec_pkg::PH_SCURVE) && ($past(phase_q) == fec_pkg::PH_FOCUS)
		|-> (timeout_q == '0))
		else $error("timeout not cleared on S-curve entry");

	// focused is only reached from the S-curve phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == fec_pkg::PH_FOCUSED) && ($past(phase_q) != fec_pkg::PH_FOCUSED)
		|-> ($past(phase_q) == fec_pkg::PH_SCURVE))
		else $error("focused reached outside S-curve phase");

endmodule

@@ tb/sv/focus_error_scurve_detector_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Focus error S-curve detector core testbench
// Runs a scripted pass over reset values, extremes and timeout handling, then
// random amplitude / focus / S-curve sequences under several register
// settings and flow-control patterns. Each result is checked against a
// behavioral model of the phase sequencer or against its scripted value.
// ----------------------------------------------------------------------------
module focus_error_scurve_detector_core_test;
	import fec_pkg::*;

	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
	localparam int PER_SETTING = 80;	// minimum requests per setting
	localparam int SETTINGS    = 6;

	// one result: packed to match m_tdata, lowest field last
	typedef struct packed {
		logic [POS_BITS-1:0]    focus_pos;
		logic [SAMPLE_BITS-1:0] amplitude;
		logic [PHASE_BITS-1:0]  phase;
	} status_t;

	// one line of the scripted part: a request or a register write
	typedef struct {
		bit                        is_write;
		logic                      act;
		logic [CMD_BITS-1:0]       cmd;
		logic [SAMPLE_BITS-1:0]    smp;
		logic [POS_BITS-1:0]       pos;
		logic [CFG_IDX_BITS-1:0]   reg_idx;
		logic [CFG_DATA_BITS-1:0]  reg_val;
		bit                        known;
		status_t                   want;
	} script_row_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
	logic [0:0]               s_tuser   = '0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;

	// model copy of the registers and state
	logic [SAMPLE_BITS-1:0]  ref_level  = RST_REFERENCE;
	logic [DIV_BITS-1:0]     noise_div  = RST_NOISE_DIV;
	logic [DIV_BITS-1:0]     capt_div   = RST_CAPT_DIV;
	logic [TIMEOUT_BITS-1:0] time_limit = RST_TIMEOUT;
	logic [PHASE_BITS-1:0]   st_phase   = PH_WAIT;
	logic [SAMPLE_BITS-1:0]  st_max     = '0;
	logic [SAMPLE_BITS-1:0]  st_min     = '1;
	logic [SAMPLE_BITS-1:0]  st_amp     = '0;
	logic [TIMEOUT_BITS-1:0] st_count   = '0;
	logic [POS_BITS-1:0]     st_fpos    = '0;

	status_t     expected_results[$];
	script_row_t script_q[$];

	int src_gap_pct    = 9;
	int sink_stall_pct = 58;
	int fail_count     = 0;
	int requests       = 0;
	int active_reqs    = 0;
	int results        = 0;
	int captures       = 0;
	int timeouts       = 0;

	focus_error_scurve_detector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),	// [1:0] command_phase, [11:2] sample, [19:12] servo_position
		.s_tuser   (s_tuser),	// [0] action
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)	// [2:0] phase, [12:3] amplitude, [20:13] focus_position
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---- model of the phase sequencer ----

	function automatic int level_gap(logic [SAMPLE_BITS-1:0] smp);
		int a;
		int r;
		a = smp;
		r = ref_level;
		return (a > r) ? a - r : r - a;
	endfunction

	// amplitude over divisor, a zero divisor counts as one
	function automatic int threshold(logic [DIV_BITS-1:0] div);
		return int'(st_amp) / ((div == 0) ? 1 : int'(div));
	endfunction

	function automatic void tick_timeout();
		if (st_count > time_limit) begin
			st_phase = PH_ERROR;
			timeouts++;
		end
		if (st_count != '1)
			st_count++;
	endfunction

	function automatic status_t detector_step(logic act, logic [CMD_BITS-1:0] cmd,
			logic [SAMPLE_BITS-1:0] smp, logic [POS_BITS-1:0] pos);
		status_t res;
		if (act == ACT_CMD) begin
			case (cmd)
				CMD_WAIT: begin
					st_phase = PH_WAIT;
					st_count = '0;
				end
				CMD_AMPL: begin
					st_phase = PH_AMPL;
					st_max   = '0;
					st_min   = '1;
					st_amp   = '0;
				end
				CMD_FOCUS: begin
					st_amp   = (st_min > st_max) ? '0 : st_max - st_min;
					st_phase = PH_FOCUS;
				end
				default: ;
			endcase
		end else begin
			case (st_phase)
				PH_WAIT: st_count = '0;
				PH_AMPL: begin
					if (smp > st_max) st_max = smp;
					if (smp < st_min) st_min = smp;
				end
				PH_FOCUS: begin
					if (level_gap(smp) > threshold(noise_div)) begin
						st_count = '0;
						st_phase = PH_SCURVE;
					end else
						tick_timeout();
				end
				PH_SCURVE: begin
					if (level_gap(smp) <= threshold(capt_div)) begin
						st_fpos  = pos;
						st_phase = PH_FOCUSED;
						captures++;
					end else
						tick_timeout();
				end
				default: ;
			endcase
		end
		res.phase     = st_phase;
		res.amplitude = st_amp;
		res.focus_pos = st_fpos;
		return res;
	endfunction

	// ---- result checking ----

	function automatic void note_fail(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR at %0t ns: %s", $time, msg);
	endfunction

	always @(posedge clk) begin : check_results
		status_t got;
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[OUT_USED_BITS-1:0];
			results++;
			if (expected_results.size() == 0)
				note_fail($sformatf("unexpected result phase %0d amplitude %0d pos %0d",
					got.phase, got.amplitude, got.focus_pos));
			else begin
				want = expected_results.pop_front();
				if (got.phase !== want.phase || got.amplitude !== want.amplitude ||
						got.focus_pos !== want.focus_pos)
					note_fail($sformatf({"result %0d: phase %0d/%0d amplitude %0d/%0d ",
						"focus_position %0d/%0d (expected/actual)"}, results,
						want.phase, got.phase, want.amplitude, got.amplitude,
						want.focus_pos, got.focus_pos));
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	// ---- drivers ----

	task automatic send_req(logic act, logic [CMD_BITS-1:0] cmd, logic [SAMPLE_BITS-1:0] smp,
			logic [POS_BITS-1:0] pos, bit known, status_t want);
		status_t model;
		bit      ignored;
		while ($urandom_range(0, 99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(IN_DATA_BITS - IN_USED_BITS){1'b0}}, pos, smp, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ignored = (act == ACT_CMD) ? (cmd == CMD_UNUSED)
			: (st_phase == PH_FOCUSED || st_phase == PH_ERROR);
		model = detector_step(act, cmd, smp, pos);
		expected_results.push_back(known ? want : model);
		requests++;
		if (!ignored) active_reqs++;
	endtask

	task automatic send_cmd(logic [CMD_BITS-1:0] cmd);
		send_req(ACT_CMD, cmd, SAMPLE_BITS'($urandom_range(0, 1023)),
			POS_BITS'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic send_smp(int smp);
		send_req(ACT_SAMPLE, CMD_BITS'($urandom_range(0, 3)), SAMPLE_BITS'(smp),
			POS_BITS'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// drop valid and wait until every result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// valid stays up across back-to-back writes, dropped after the last one
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val,
			bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_REFERENCE: ref_level  = val[SAMPLE_BITS-1:0];
			REG_NOISE_DIV: noise_div  = val[DIV_BITS-1:0];
			REG_CAPT_DIV:  capt_div   = val[DIV_BITS-1:0];
			REG_TIMEOUT:   time_limit = val[TIMEOUT_BITS-1:0];
			default: ;
		endcase
		if (last) cfg_valid <= 1'b0;
	endtask

	// unused upper bits of the narrow registers get random junk
	task automatic load_settings(int lvl, int nd, int cd, int tl);
		write_reg(REG_REFERENCE, {6'($urandom), 10'(lvl)}, 0);
		write_reg(REG_NOISE_DIV, {8'($urandom), 8'(nd)}, 0);
		write_reg(REG_CAPT_DIV, {8'($urandom), 8'(cd)}, 0);
		write_reg(REG_TIMEOUT, 16'(tl), 1);
	endtask

	// ---- stimulus helpers ----

	function automatic int clip(int v);
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	// a sample whose distance from the level falls in [lo, hi], before clipping
	function automatic int around(int lvl, int lo, int hi);
		int off;
		off = $urandom_range(lo, hi);
		return clip($urandom_range(0, 1) ? lvl + off : lvl - off);
	endfunction

	function automatic script_row_t req_row(logic act, logic [CMD_BITS-1:0] cmd, int smp,
			int pos);
		script_row_t r;
		r.is_write = 0;
		r.act      = act;
		r.cmd      = cmd;
		r.smp      = SAMPLE_BITS'(smp);
		r.pos      = POS_BITS'(pos);
		r.reg_idx  = '0;
		r.reg_val  = '0;
		r.known    = 0;
		r.want     = '0;
		return r;
	endfunction

	function automatic script_row_t chk_row(logic act, logic [CMD_BITS-1:0] cmd, int smp,
			int pos, logic [PHASE_BITS-1:0] ph, int amp, int fpos);
		script_row_t r;
		r = req_row(act, cmd, smp, pos);
		r.known          = 1;
		r.want.phase     = ph;
		r.want.amplitude = SAMPLE_BITS'(amp);
		r.want.focus_pos = POS_BITS'(fpos);
		return r;
	endfunction

	function automatic script_row_t reg_row(logic [CFG_IDX_BITS-1:0] idx, int val);
		script_row_t r;
		r = req_row(ACT_CMD, CMD_WAIT, 0, 0);
		r.is_write = 1;
		r.reg_idx  = idx;
		r.reg_val  = CFG_DATA_BITS'(val);
		return r;
	endfunction

	// mostly well-formed measure / focus / S-curve runs, some raw noise
	task automatic random_burst();
		int center;
		int span;
		int lvl;
		int thr;
		if ($urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 3) == 0) send_cmd(CMD_WAIT);
			send_cmd(CMD_AMPL);
			center = $urandom_range(0, 1023);
			span   = $urandom_range(0, 1023);
			repeat ($urandom_range(1, 5))
				send_smp(clip(center - span / 2 + int'($urandom_range(0, span))));
			if ($urandom_range(0, 4) == 0) send_smp($urandom_range(0, 1) ? 1023 : 0);
			send_cmd(CMD_FOCUS);
			lvl = ref_level;
			thr = threshold(noise_div);
			repeat ($urandom_range(0, 4)) send_smp(around(lvl, 0, thr));
			if ($urandom_range(0, 4) != 0) send_smp(around(lvl, thr + 1, thr + 1 + st_amp));
			thr = threshold(capt_div);
			repeat ($urandom_range(0, 4)) send_smp(around(lvl, thr + 1, 1023));
			if ($urandom_range(0, 4) != 0) send_smp(around(lvl, 0, thr));
			repeat ($urandom_range(0, 2)) send_smp($urandom_range(0, 1023));
		end else begin
			repeat ($urandom_range(1, 6))
				send_req(1'($urandom_range(0, 1)), CMD_BITS'($urandom_range(0, 3)),
					SAMPLE_BITS'($urandom_range(0, 1023)),
					POS_BITS'($urandom_range(0, 255)), 1'b0, '0);
		end
	endtask

	// ---- main sequence ----

	initial begin
		int base;
		script_row_t r;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted pass, reset register values
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_UNUSED, 1023, 255, PH_WAIT, 0, 0));
		script_q.push_back(chk_row(ACT_CMD, CMD_UNUSED, 0, 0, PH_WAIT, 0, 0));
		// focus before any measurement: min above max clamps to zero
		script_q.push_back(chk_row(ACT_CMD, CMD_FOCUS, 0, 0, PH_FOCUS, 0, 0));
		script_q.push_back(chk_row(ACT_CMD, CMD_WAIT, 1023, 255, PH_WAIT, 0, 0));
		script_q.push_back(chk_row(ACT_CMD, CMD_AMPL, 0, 0, PH_AMPL, 0, 0));
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_WAIT, 0, 0, PH_AMPL, 0, 0));
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_UNUSED, 1023, 255, PH_AMPL, 0, 0));
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_WAIT, 512, 0, PH_AMPL, 0, 0));
		script_q.push_back(chk_row(ACT_CMD, CMD_FOCUS, 0, 0, PH_FOCUS, 1023, 0));
		script_q.push_back(req_row(ACT_SAMPLE, CMD_WAIT, 512, 1));
		script_q.push_back(req_row(ACT_SAMPLE, CMD_WAIT, 800, 2));
		script_q.push_back(req_row(ACT_SAMPLE, CMD_WAIT, 1023, 8'hAA));
		script_q.push_back(req_row(ACT_SAMPLE, CMD_WAIT, 600, 8'h55));
		// focused holds against samples and the unused command
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_WAIT, 0, 8'h12, PH_FOCUSED, 1023, 8'h55));
		script_q.push_back(chk_row(ACT_CMD, CMD_UNUSED, 0, 0, PH_FOCUSED, 1023, 8'h55));
		script_q.push_back(chk_row(ACT_CMD, CMD_AMPL, 0, 0, PH_AMPL, 0, 8'h55));
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_WAIT, 0, 255, PH_AMPL, 0, 8'h55));
		// zero timeout limit: second quiet sample errors
		script_q.push_back(reg_row(REG_TIMEOUT, 0));
		script_q.push_back(chk_row(ACT_CMD, CMD_WAIT, 0, 0, PH_WAIT, 0, 8'h55));
		script_q.push_back(chk_row(ACT_CMD, CMD_FOCUS, 0, 0, PH_FOCUS, 0, 8'h55));
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_WAIT, 512, 0, PH_FOCUS, 0, 8'h55));
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_WAIT, 512, 0, PH_ERROR, 0, 8'h55));
		script_q.push_back(chk_row(ACT_SAMPLE, CMD_WAIT, 1023, 255, PH_ERROR, 0, 8'h55));

		foreach (script_q[i]) begin
			r = script_q[i];
			if (r.is_write) begin
				wait_idle();
				write_reg(r.reg_idx, r.reg_val, 1);
			end else
				send_req(r.act, r.cmd, r.smp, r.pos, r.known, r.want);
		end

		// random part under several register settings
		for (int p = 0; p < SETTINGS; p++) begin
			wait_idle();
			case (p)
				0: load_settings(512, 4, 8, 20);
				1: load_settings(0, 1, 255, 3);
				2: load_settings(1023, 255, 1, 0);
				3: load_settings($urandom_range(0, 1023), 0, 0, 65535);
				4: load_settings($urandom_range(0, 1023), $urandom_range(1, 255),
					$urandom_range(1, 255), 65534);
				default: load_settings($urandom_range(0, 1023), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 15));
			endcase
			// sender light / receiver heavy, then swapped, then none
			case (p / 2)
				0: begin src_gap_pct = 9;  sink_stall_pct = 58; end
				1: begin src_gap_pct = 58; sink_stall_pct = 9;  end
				default: begin src_gap_pct = 0; sink_stall_pct = 0; end
			endcase
			base = requests;
			while (requests - base < PER_SETTING)
				random_burst();
		end

		wait_idle();
		repeat (24) @(posedge clk);

		$display("Summary: %0d requests (%0d state-changing), %0d results, %0d settings",
			requests, active_reqs, results, SETTINGS + 1);
		$display("Summary: %0d focus captures and %0d timeout errors reached",
			captures, timeouts);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("Timeout: %0d results still outstanding", expected_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
